/* sv/qfr_pkg.sv */
// shared types and constants for the collapsing queue
`timescale 1ns / 1ps

package qfr_pkg;

  localparam int DEF_DEPTH      = 16;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int ACT_W   = 3;
  localparam int IO_DW   = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;
  localparam int IN_TW   = 40;
  localparam int OUT_TW  = 40;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH       = 3'd0,
    ACT_POP        = 3'd1,
    ACT_PEEK_FRONT = 3'd2,
    ACT_PEEK_REAR  = 3'd3,
    ACT_READ_AT    = 3'd4,
    ACT_REMOVE_AT  = 3'd5
  } action_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic wr;
    logic rm;
  } cell_ctl_t;

endpackage

/* sv/fifo_queue_with_remove_at.sv */
// collapsing queue top level: action decode, row of slot cells, result register
//
// channel | dir | tdata fields (low bit up)
// in_     | in  | action[2:0] push_data[34:3] position[38:35] zero[39]
// out_    | out | out_data[31:0] found[32] entry_count[37:33] is_empty[38] is_full[39]
//
// one request per cycle while the result is taken; the result is registered and shows in the cycle after accept
// every cell compares its index with the broadcast one and shifts in the same cycle
// rst_n clears the count and the result valid; slot words hold no reset
// a stalled result blocks new requests only while out_tready is low
`timescale 1ns / 1ps

module fifo_queue_with_remove_at #(
  parameter int DEPTH      = qfr_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = qfr_pkg::DEF_DATA_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // action[2:0], push_data[34:3], position[38:35]
  input  logic [qfr_pkg::IN_TW-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // out_data[31:0], found[32], entry_count[37:33], is_empty[38], is_full[39]
  output logic [qfr_pkg::OUT_TW-1:0] out_tdata
);
  import qfr_pkg::*;

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [ACT_W-1:0]      act;
  logic [IO_DW-1:0]      push_data;
  logic [POS_W-1:0]      position;
  logic                  fire;

  logic [CW-1:0]         count_r, count_nxt;
  logic                  empty, full, pos_ok;
  logic [CMPW-1:0]       pos_w, cnt_w;

  logic                  ok, give_data;
  cell_ctl_t             ctl;
  logic [IW-1:0]         wr_idx, rm_idx, rd_idx;
  logic [DATA_WIDTH-1:0] wr_data, rd_word;
  logic [63:0]           push_ext, rd_ext;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

  logic                  out_valid_r, out_valid_nxt;
  logic [IO_DW-1:0]      out_data_r, out_data_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;

  assign act       = in_tdata[2:0];
  assign push_data = in_tdata[34:3];
  assign position  = in_tdata[38:35];

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  assign empty  = (count_r == '0);
  assign full   = (count_r == FULL_CNT);
  assign pos_w  = CMPW'(position);
  assign cnt_w  = CMPW'(count_r);
  assign pos_ok = (pos_w < cnt_w);

  assign push_ext = 64'(push_data);
  assign wr_data  = push_ext[DATA_WIDTH-1:0];
  assign wr_idx   = IW'(count_r);

  always_comb begin
    ok        = 1'b0;
    give_data = 1'b0;
    ctl       = '0;
    rm_idx    = '0;
    rd_idx    = '0;
    case (act)
      ACT_PUSH: begin
        ok     = !full;
        ctl.wr = fire && !full;
      end
      ACT_POP: begin
        ok        = !empty;
        give_data = 1'b1;
        ctl.rm    = fire && !empty;
      end
      ACT_PEEK_FRONT: begin
        ok        = !empty;
        give_data = 1'b1;
      end
      ACT_PEEK_REAR: begin
        ok        = !empty;
        give_data = 1'b1;
        rd_idx    = IW'(count_r - CW'(1));
      end
      ACT_READ_AT: begin
        ok        = pos_ok;
        give_data = 1'b1;
        rd_idx    = IW'(pos_w);
      end
      ACT_REMOVE_AT: begin
        ok        = pos_ok;
        give_data = 1'b1;
        rm_idx    = IW'(pos_w);
        rd_idx    = IW'(pos_w);
        ctl.rm    = fire && pos_ok;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] nb;
    if (g == DEPTH - 1) begin : g_last
      assign nb = cell_data[g];
    end else begin : g_mid
      assign nb = cell_data[g+1];
    end
    qfr_cell #(
      .IDX        (g),
      .IW         (IW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .wr_idx  (wr_idx),
      .rm_idx  (rm_idx),
      .rd_idx  (rd_idx),
      .wr_data (wr_data),
      .nb_data (nb),
      .data    (cell_data[g]),
      .rd_data (cell_rd[g])
    );
  end

  // only the addressed cell drives nonzero read data
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  assign rd_ext = 64'(rd_word);

  always_comb begin
    count_nxt = count_r;
    if (ctl.wr) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rm) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_found_nxt = out_found_r;
    out_count_nxt = out_count_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (ok && give_data) ? rd_ext[IO_DW-1:0] : '0;
      out_found_nxt = ok;
      out_count_nxt = count_nxt;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_found_r <= out_found_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(out_count_r == FULL_CNT), (out_count_r == '0),
                       COUNT_W'(out_count_r), out_found_r, out_data_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (act == ACT_PUSH) && !full |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted push did not add an entry");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (act == ACT_POP) && !empty |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not remove an entry");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("request blocked with no pending result");

endmodule

/* sv/qfr_cell.sv */
// one queue slot: loads on push, takes its rear neighbor's word on a remove at or before its index
`timescale 1ns / 1ps

module qfr_cell #(
  parameter int IDX        = 0,
  parameter int IW         = 4,
  parameter int DATA_WIDTH = qfr_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  qfr_pkg::cell_ctl_t    ctl,
  input  logic [IW-1:0]         wr_idx,
  input  logic [IW-1:0]         rm_idx,
  input  logic [IW-1:0]         rd_idx,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] nb_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_data
);
  import qfr_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DATA_WIDTH-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr && (wr_idx == MY_IDX)) begin
      data_r <= wr_data;
    end else if (ctl.rm && (MY_IDX >= rm_idx)) begin
      data_r <= nb_data;
    end
  end

  assign data    = data_r;
  assign rd_data = (rd_idx == MY_IDX) ? data_r : '0;

endmodule
